/* hw/rtl/per_account_order_rate_limiter_defines.svh */
// Assertion macros shared by the rate limiter RTL.
// Needs i_clk and i_rst_n in the scope that uses them.
`ifndef PER_ACCOUNT_ORDER_RATE_LIMITER_DEFINES_SVH
`define PER_ACCOUNT_ORDER_RATE_LIMITER_DEFINES_SVH

// Clocked property, switched off while reset is held
`define POARL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition that must never be true at a clock edge out of reset
`define POARL_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

/* hw/rtl/poarl_pkg.sv */
// Shared types, constants and helpers for the order rate limiter.
// No dependencies; used by the interfaces, the table and the top level.
package poarl_pkg;

    // Table geometry (entry count is a power of two)
    localparam int ACCT_BITS   = 10;
    localparam int ACCOUNTS    = 1 << ACCT_BITS;
    localparam int COUNT_BITS  = 20;

    // Field widths
    localparam int KIND_W      = 2;
    localparam int ACCT_ID_W   = 10;
    localparam int TIME_W      = 64;
    localparam int LIMIT_W     = 20;
    localparam int VERDICT_W   = 3;
    localparam int DEST_W      = 2;
    localparam int REG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;
    localparam int CMP_W       = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

    localparam logic [TIME_W-1:0]     ONE_SECOND_NS = TIME_W'(64'd1_000_000_000);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX     = {COUNT_BITS{1'b1}};

    // Message kinds
    localparam logic [KIND_W-1:0] K_NEW       = 2'd0;
    localparam logic [KIND_W-1:0] K_CANCEL    = 2'd1;
    localparam logic [KIND_W-1:0] K_REPLACE   = 2'd2;
    localparam logic [KIND_W-1:0] K_HEARTBEAT = 2'd3;

    // Verdicts
    localparam logic [VERDICT_W-1:0] V_ACCEPTED   = 3'd0;
    localparam logic [VERDICT_W-1:0] V_HEARTBEAT  = 3'd1;
    localparam logic [VERDICT_W-1:0] V_AUTH_REJ   = 3'd2;
    localparam logic [VERDICT_W-1:0] V_RATE_LIM   = 3'd3;
    localparam logic [VERDICT_W-1:0] V_QUEUE_FULL = 3'd4;

    // Destination queues
    localparam logic [DEST_W-1:0] D_NEW     = 2'd0;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_AUTH_EN    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LIM_NEW    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LIM_CANCEL = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_LIM_REPL   = 2'd3;

    typedef logic [ACCT_BITS-1:0]  t_slot;
    typedef logic [COUNT_BITS-1:0] t_count;

    // One table entry: window start and the three per-kind counters
    typedef struct packed {
        logic [TIME_W-1:0] win_origin;
        t_count            new_cnt;
        t_count            cancel_cnt;
        t_count            replace_cnt;
    } t_entry;

    typedef struct packed {
        logic  en;
        t_slot addr;
    } t_tbl_rd;

    typedef struct packed {
        logic   en;
        t_slot  addr;
        t_entry data;
    } t_tbl_wr;

    // Account id wraps onto the table
    function automatic t_slot slot_of(input logic [ACCT_ID_W-1:0] id);
        logic [ACCT_BITS+ACCT_ID_W-1:0] wide;
        wide = (ACCT_BITS + ACCT_ID_W)'(id);
        return wide[ACCT_BITS-1:0];
    endfunction

endpackage

/* hw/rtl/poarl_ifs.sv */
// Valid/ready channel interfaces: message in, verdict out, register writes.
// Depends on poarl_pkg.

interface poarl_msg_if;
    import poarl_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    message_kind;
    logic [ACCT_ID_W-1:0] account_id;
    logic [TIME_W-1:0]    arrival_time;
    logic                 auth_ok;
    logic                 new_queue_full;
    logic                 cancel_queue_full;
    logic                 replace_queue_full;

    modport source (output valid, message_kind, account_id, arrival_time, auth_ok,
                    new_queue_full, cancel_queue_full, replace_queue_full,
                    input ready);
    modport sink   (input valid, message_kind, account_id, arrival_time, auth_ok,
                    new_queue_full, cancel_queue_full, replace_queue_full,
                    output ready);
endinterface

interface poarl_res_if;
    import poarl_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [VERDICT_W-1:0] verdict;
    logic                 success;
    logic                 push_strobe;
    logic [DEST_W-1:0]    destination;

    modport source (output valid, verdict, success, push_strobe, destination,
                    input ready);
    modport sink   (input valid, verdict, success, push_strobe, destination,
                    output ready);
endinterface

interface poarl_cfg_if;
    import poarl_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [REG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/per_account_order_rate_limiter.sv */
// Channel   Dir  Modport  Contents
// i_msg     in   sink     kind, account, timestamp, auth flag, queue-full flags
// o_res     out  source   verdict, success, push strobe, destination queue
// i_cfg     in   sink     register index and write data, always ready
//
// Each word goes through a table read, then check and write back.
// The single table RAM port pair sets this; one word is in flight at a time.
// After reset a clearing sweep zeroes all 1024 table entries; no word is
// taken until it ends, register writes are taken throughout.
// A stalled result sits in the output register; the next word may still be
// read, but it waits in the check stage until the result register frees.
// Depends on poarl_pkg, poarl_ifs, poarl_table and the assertion macros.
`include "per_account_order_rate_limiter_defines.svh"

module per_account_order_rate_limiter (
    input  logic   i_clk,
    input  logic   i_rst_n,
    poarl_msg_if.sink   i_msg,
    poarl_res_if.source o_res,
    poarl_cfg_if.sink   i_cfg
);
    import poarl_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    // Configuration registers
    logic               r_auth_en;
    logic [LIMIT_W-1:0] r_lim_new;
    logic [LIMIT_W-1:0] r_lim_cancel;
    logic [LIMIT_W-1:0] r_lim_repl;

    // Control and captured word
    logic               r_state;
    logic               n_state;
    logic [KIND_W-1:0]  r_kind;
    t_slot              r_slot;
    logic [TIME_W-1:0]  r_time;
    logic               r_auth;
    logic [2:0]         r_full;

    // Output register
    logic                 r_out_valid;
    logic [VERDICT_W-1:0] r_out_verdict;
    logic                 r_out_success;
    logic                 r_out_push;
    logic [DEST_W-1:0]    r_out_dest;

    // Table connections
    t_tbl_rd tbl_rd;
    t_tbl_wr tbl_wr;
    t_entry  rd_entry;
    logic    clearing;

    // Check-stage signals
    logic                 msg_acc;
    logic                 slot_free;
    logic                 done;
    logic                 expired;
    t_entry               base;
    t_entry               upd;
    t_count               cnt;
    logic [LIMIT_W-1:0]   lim;
    logic                 limited;
    logic                 full_sel;
    logic                 is_hb;
    logic                 auth_rej;
    logic [VERDICT_W-1:0] verdict;

    poarl_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd       (tbl_rd),
        .i_wr       (tbl_wr),
        .o_rd_data  (rd_entry),
        .o_clearing (clearing)
    );

    // Register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auth_en    <= 1'b0;
            r_lim_new    <= '0;
            r_lim_cancel <= '0;
            r_lim_repl   <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_AUTH_EN:    r_auth_en    <= i_cfg.data[0];
                REG_LIM_NEW:    r_lim_new    <= LIMIT_W'(i_cfg.data);
                REG_LIM_CANCEL: r_lim_cancel <= LIMIT_W'(i_cfg.data);
                REG_LIM_REPL:   r_lim_repl   <= LIMIT_W'(i_cfg.data);
                default: ;
            endcase
        end
    end

    // Intake and table read
    assign i_msg.ready = (r_state == ST_IDLE) && !clearing;
    assign msg_acc     = i_msg.valid && i_msg.ready;
    assign tbl_rd.en   = msg_acc;
    assign tbl_rd.addr = slot_of(i_msg.account_id);

    always_ff @(posedge i_clk) begin
        if (msg_acc) begin
            r_kind <= i_msg.message_kind;
            r_slot <= slot_of(i_msg.account_id);
            r_time <= i_msg.arrival_time;
            r_auth <= i_msg.auth_ok;
            r_full <= {i_msg.replace_queue_full, i_msg.cancel_queue_full,
                       i_msg.new_queue_full};
        end
    end

    // Window rollover
    assign expired = (r_time - rd_entry.win_origin) >= ONE_SECOND_NS;

    always_comb begin
        base = rd_entry;
        if (expired) begin
            base = '{win_origin: r_time, new_cnt: '0, cancel_cnt: '0,
                     replace_cnt: '0};
        end
    end

    // Counter and limit of this kind
    always_comb begin
        case (r_kind)
            K_NEW: begin
                cnt = base.new_cnt;
                lim = r_lim_new;
                full_sel = r_full[0];
            end
            K_CANCEL: begin
                cnt = base.cancel_cnt;
                lim = r_lim_cancel;
                full_sel = r_full[1];
            end
            default: begin
                cnt = base.replace_cnt;
                lim = r_lim_repl;
                full_sel = r_full[2];
            end
        endcase
    end

    assign limited = (CMP_W'(cnt) >= CMP_W'(lim)) || (cnt == COUNT_MAX);

    always_comb begin
        upd = base;
        if (!limited) begin
            case (r_kind)
                K_NEW:    upd.new_cnt     = base.new_cnt + t_count'(1);
                K_CANCEL: upd.cancel_cnt  = base.cancel_cnt + t_count'(1);
                default:  upd.replace_cnt = base.replace_cnt + t_count'(1);
            endcase
        end
    end

    // Verdict
    assign is_hb    = (r_kind == K_HEARTBEAT);
    assign auth_rej = r_auth_en && !r_auth;

    always_comb begin
        if (is_hb) begin
            verdict = V_HEARTBEAT;
        end else if (auth_rej) begin
            verdict = V_AUTH_REJ;
        end else if (limited) begin
            verdict = V_RATE_LIM;
        end else if (full_sel) begin
            verdict = V_QUEUE_FULL;
        end else begin
            verdict = V_ACCEPTED;
        end
    end

    // Retire when the output register is free
    assign slot_free = !r_out_valid || o_res.ready;
    assign done      = (r_state == ST_EXEC) && slot_free;

    assign tbl_wr.en   = done && !is_hb && !auth_rej;
    assign tbl_wr.addr = r_slot;
    assign tbl_wr.data = upd;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (msg_acc) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_verdict <= verdict;
            r_out_success <= (verdict == V_ACCEPTED) || (verdict == V_HEARTBEAT);
            r_out_push    <= (verdict == V_ACCEPTED);
            r_out_dest    <= is_hb ? D_NEW : DEST_W'(r_kind);
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.verdict     = r_out_verdict;
    assign o_res.success     = r_out_success;
    assign o_res.push_strobe = r_out_push;
    assign o_res.destination = r_out_dest;

    // Checks
    `POARL_ASSERT(a_acc_to_exec, msg_acc |=> (r_state == ST_EXEC), "accepted word did not reach check stage")
    `POARL_NEVER(a_wr_outside_exec, tbl_wr.en && (r_state != ST_EXEC), "table write outside check stage")
    `POARL_ASSERT(a_push_accepted, (r_out_valid && r_out_push) |-> (r_out_verdict == V_ACCEPTED), "push without accept")
    `POARL_ASSERT(a_exec_hold, ((r_state == ST_EXEC) && !slot_free) |=> ((r_state == ST_EXEC) && $stable(r_slot) && $stable(r_kind)), "stalled word lost")

endmodule

/* hw/rtl/poarl_table.sv */
// Per-account window table: one synchronous RAM, registered read data,
// and the clearing sweep that runs after reset. Depends on poarl_pkg.
module poarl_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  poarl_pkg::t_tbl_rd i_rd,
    input  poarl_pkg::t_tbl_wr i_wr,
    output poarl_pkg::t_entry  o_rd_data,
    output logic               o_clearing
);
    import poarl_pkg::*;

    t_entry r_mem [ACCOUNTS];
    t_entry r_rd_data;
    logic   r_clr_busy;
    t_slot  r_clr_addr;
    t_slot  n_clr_addr;
    logic   n_clr_busy;

    t_slot  wr_addr;
    t_entry wr_data;
    logic   wr_en;

    // Clearing sweep, one entry per cycle
    always_comb begin
        n_clr_busy = r_clr_busy;
        n_clr_addr = r_clr_addr;
        if (r_clr_busy) begin
            n_clr_addr = r_clr_addr + t_slot'(1);
            if (r_clr_addr == t_slot'(ACCOUNTS - 1)) begin
                n_clr_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clr_busy <= n_clr_busy;
            r_clr_addr <= n_clr_addr;
        end
    end

    // Sweep owns the write port while it runs
    always_comb begin
        if (r_clr_busy) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = i_wr.en;
            wr_addr = i_wr.addr;
            wr_data = i_wr.data;
        end
    end

    // RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clr_busy;

endmodule
